/* rtl/cjs_pkg.sv */
// types and constants for the cpu job scheduler
// no dependencies
package cjs_pkg;
	localparam int SLOT_W = 4;
	localparam int BURST_W = 12;
	localparam int TIME_W = 16;

	localparam logic [2:0] POL_FCFS = 3'd0;
	localparam logic [2:0] POL_RR = 3'd1;
	localparam logic [2:0] POL_SPN = 3'd2;
	localparam logic [2:0] POL_SRT = 3'd3;
	localparam logic [2:0] POL_HRRN = 3'd4;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [0:0] REG_POLICY = 1'b0;
	localparam logic [0:0] REG_QUANTUM = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [SLOT_W-1:0] slot;
		logic [BURST_W-1:0] burst_length;
	} in_item_t;

	typedef struct packed {
		logic ran_valid;
		logic [SLOT_W-1:0] ran_slot;
		logic job_done;
		logic add_error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_SERVE,
		ST_WRITE
	} state_t;
endpackage

/* rtl/cpu_job_scheduler_core.sv */
// cpu job scheduler top level: sequencer, job table and shared compare unit
// depends on cjs_pkg and cjs_ram
//
// channel   signals                         direction
// item in   start, busy, in_item            in
// result    done, out_item                  out (strobe, no back pressure)
// config    cfg_valid, cfg_ready, cfg_index, cfg_wdata   in
//
// an add is written in the scan state, which also registers its result; a tick that scans
// the whole table steps every slot through the scan, mul and write states, reading one table
// entry at a time through a single ram port and one shared multiply-compare unit (read,
// multiply, compare per slot). a held job (fcfs, spn, hrrn, or a round robin slice not used
// up) skips the scan and goes straight to serve; round robin stops at the first occupied slot
// in its order. reset clears occupied bits, time and holder and restores default config;
// table rams hold garbage until written. results cannot be stalled; done pulses for one cycle
// and the next item can be taken at the edge that ends it.
module cpu_job_scheduler_core
	import cjs_pkg::*;
#(
	parameter int NUM_SLOTS = 16,
	parameter int BURST_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_item_t in_item,
	output logic done,
	output out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_wdata
);
	localparam int SW = $clog2(NUM_SLOTS);
	localparam int RAM_W = 2*BURST_BITS + TIME_W;

	state_t state_q, state_d;
	logic [2:0] policy_q;
	logic [7:0] quantum_q;
	logic [NUM_SLOTS-1:0] occ_q;
	logic [TIME_W-1:0] now_q;
	logic [SW-1:0] holder_q;
	logic holder_act_q;
	logic [7:0] slice_q;
	in_item_t item_q;
	logic [SW:0] cnt_q;
	logic [SW-1:0] cur_q, best_q, sel_q;
	logic best_ok_q;
	logic [BURST_BITS-1:0] rem_best_q, org_best_q;
	logic [TIME_W-1:0] age_best_q;
	logic [TIME_W+BURST_BITS-1:0] ls_q, lb_q;
	logic [2:0] pol;
	logic [BURST_BITS-1:0] bl;
	logic [SW-1:0] add_idx;
	logic add_in_range;

	// ram entry: remaining, original, arrival
	logic we;
	logic [SW-1:0] addr;
	logic [RAM_W-1:0] wdata, rdata;
	logic [BURST_BITS-1:0] r_rem, r_org;
	logic [TIME_W-1:0] r_arr, r_age;

	cjs_ram #(.WIDTH(RAM_W), .DEPTH(NUM_SLOTS)) u_tab (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign r_rem = rdata[RAM_W-1 -: BURST_BITS];
	assign r_org = rdata[TIME_W +: BURST_BITS];
	assign r_arr = rdata[TIME_W-1:0];
	assign r_age = now_q - r_arr;
	assign pol = (policy_q > POL_HRRN) ? POL_FCFS : policy_q;
	assign bl = BURST_BITS'(item_q.burst_length);
	assign add_idx = SW'(item_q.slot);
	assign add_in_range = 32'(item_q.slot) < 32'(NUM_SLOTS);

	logic [BURST_BITS-1:0] best_rem_x;
	logic [BURST_BITS-1:0] best_org_b;
	assign best_org_b = org_best_q;
	assign best_rem_x = rem_best_q;

	// candidate order for scan; round robin walks from its start slot
	logic [SW-1:0] rr_start, scan_slot;
	logic [SW:0] rr_sum;
	logic hold_np, hold_rr;
	always_comb begin
		rr_sum = {1'b0, holder_q} + (holder_act_q ? 1'b1 : 1'b0);
		if (rr_sum >= (SW+1)'(NUM_SLOTS)) rr_sum = rr_sum - (SW+1)'(NUM_SLOTS);
		rr_start = rr_sum[SW-1:0];
		hold_np = (pol != POL_RR) && (pol != POL_SRT) && holder_act_q && occ_q[holder_q];
		hold_rr = (pol == POL_RR) && holder_act_q && occ_q[holder_q] && (slice_q != 8'd0);
	end

	logic [SW:0] sc_sum;
	always_comb begin
		sc_sum = {1'b0, rr_start} + cnt_q;
		if (pol == POL_RR) begin
			if (sc_sum >= (SW+1)'(NUM_SLOTS)) sc_sum = sc_sum - (SW+1)'(NUM_SLOTS);
			scan_slot = sc_sum[SW-1:0];
		end else begin
			scan_slot = cnt_q[SW-1:0];
		end
	end

	// compare for the slot in cur_q; ls/lb hold hrrn products from the mul step
	logic better;
	always_comb begin
		case (pol)
			POL_RR: better = 1'b0;
			POL_SPN: better = r_org < best_org_b;
			POL_SRT: better = r_rem < best_rem_x;
			POL_HRRN: better = ls_q > lb_q;
			default: better = r_age > age_best_q;
		endcase
	end

	logic [BURST_BITS-1:0] new_rem;
	assign new_rem = (r_rem != '0) ? r_rem - 1'b1 : r_rem;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		addr = cur_q;
		wdata = {r_rem & '0, r_org, r_arr};
		case (state_q)
			ST_IDLE: begin
				addr = SW'(in_item.slot);
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (item_q.cmd == CMD_ADD) begin
					addr = add_idx;
					we = add_in_range && !occ_q[add_idx];
					wdata = {(bl == '0) ? BURST_BITS'(1) : bl,
						(bl == '0) ? BURST_BITS'(1) : bl, now_q};
					state_d = ST_IDLE;
				end else if (hold_np || hold_rr || cnt_q == (SW+1)'(NUM_SLOTS)) begin
					addr = sel_q;
					state_d = ST_SERVE;
				end else begin
					addr = scan_slot;
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_SCAN;
			ST_SERVE: begin
				addr = sel_q;
				we = best_ok_q;
				wdata = {new_rem, r_org, r_arr};
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sel_q = best_q;
		if (hold_np || hold_rr) sel_q = holder_q;
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			policy_q <= POL_FCFS;
			quantum_q <= 8'd2;
			occ_q <= '0;
			now_q <= '0;
			holder_q <= '0;
			holder_act_q <= 1'b0;
			slice_q <= '0;
			done <= 1'b0;
			cnt_q <= '0;
			best_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POLICY: policy_q <= cfg_wdata[2:0];
					REG_QUANTUM: quantum_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					best_ok_q <= 1'b0;
				end
				ST_SCAN: begin
					if (item_q.cmd == CMD_ADD) begin
						done <= 1'b1;
						if (we) occ_q[add_idx] <= 1'b1;
					end else if (hold_np || hold_rr) begin
						best_ok_q <= 1'b1;
					end else if (cnt_q != (SW+1)'(NUM_SLOTS)) begin
						cur_q <= scan_slot;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					ls_q <= r_age * best_org_b;
					lb_q <= age_best_q * r_org;
				end
				ST_WRITE: begin
					if (occ_q[cur_q] && (!best_ok_q || better)) begin
						best_ok_q <= 1'b1;
						best_q <= cur_q;
						rem_best_q <= r_rem;
						org_best_q <= r_org;
						age_best_q <= r_age;
						if (pol == POL_RR) cnt_q <= (SW+1)'(NUM_SLOTS);
					end
				end
				ST_SERVE: begin
					done <= 1'b1;
					now_q <= now_q + 1'b1;
					if (best_ok_q) begin
						slice_q <= (holder_act_q && holder_q == sel_q && slice_q != 8'd0) ?
							slice_q - 1'b1 :
							((quantum_q == 8'd0) ? 8'd0 : quantum_q - 1'b1);
						holder_q <= sel_q;
						if (new_rem == '0) begin
							occ_q[sel_q] <= 1'b0;
							holder_act_q <= 1'b0;
						end else begin
							holder_act_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) item_q <= in_item;
		if (state_q == ST_SCAN && item_q.cmd == CMD_ADD) begin
			out_item.ran_valid <= 1'b0;
			out_item.ran_slot <= '0;
			out_item.job_done <= 1'b0;
			out_item.add_error <= !we;
		end else if (state_q == ST_SERVE) begin
			out_item.ran_valid <= best_ok_q;
			out_item.ran_slot <= best_ok_q ? SLOT_W'(sel_q) : '0;
			out_item.job_done <= best_ok_q && (new_rem == '0);
			out_item.add_error <= 1'b0;
		end
	end
endmodule

/* rtl/cjs_ram.sv */
// generic single-port ram with registered read
// no dependencies
module cjs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* dv/cpu_job_scheduler_core_tb.sv */
// self-checking testbench for cpu_job_scheduler_core: directed table, then random phases
// depends on cjs_pkg and the scheduler rtl
module cpu_job_scheduler_core_tb;
	import cjs_pkg::*;

	localparam int NSLOT = 16;
	localparam int SETTLE = NSLOT * 3 + 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t in_item = '0;
	logic done;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_wdata = '0;

	cpu_job_scheduler_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// scheduler mirror
	logic [2:0] m_policy;
	logic [7:0] m_quantum;
	logic m_occ [NSLOT];
	logic [BURST_W-1:0] m_rem [NSLOT];
	logic [BURST_W-1:0] m_orig [NSLOT];
	logic [TIME_W-1:0] m_arr [NSLOT];
	logic [TIME_W-1:0] m_now;
	logic [SLOT_W-1:0] m_hslot;
	logic m_hact;
	logic [7:0] m_slice;

	out_item_t sched_results [$];
	int errors = 0;
	int idle_pct = 0;

	function automatic logic [TIME_W-1:0] age(int s);
		return m_now - m_arr[s];
	endfunction

	function automatic int choose_job();
		int best;
		logic [2:0] pol;
		logic [SLOT_W-1:0] c;
		logic better;
		logic [27:0] ls, lb;
		best = -1;
		pol = (m_policy > POL_HRRN) ? POL_FCFS : m_policy;
		if (pol != POL_RR && pol != POL_SRT && m_hact && m_occ[m_hslot])
			return m_hslot;
		if (pol == POL_RR) begin
			c = m_hslot;
			if (m_hact && m_occ[c] && m_slice > 0)
				return c;
			if (m_hact)
				c = c + 1'b1;
			for (int k = 0; k < NSLOT; k++) begin
				if (m_occ[c])
					return c;
				c = c + 1'b1;
			end
			return -1;
		end
		for (int s = 0; s < NSLOT; s++) begin
			if (m_occ[s]) begin
				if (best < 0) begin
					best = s;
				end else begin
					case (pol)
						POL_FCFS: better = age(s) > age(best);
						POL_SPN: better = m_orig[s] < m_orig[best];
						POL_SRT: better = m_rem[s] < m_rem[best];
						default: begin
							ls = age(s) * m_orig[best];
							lb = age(best) * m_orig[s];
							better = ls > lb;
						end
					endcase
					if (better)
						best = s;
				end
			end
		end
		return best;
	endfunction

	function automatic out_item_t sched_step(in_item_t it);
		out_item_t r;
		int sel;
		logic [7:0] q;
		logic [BURST_W-1:0] b;
		r = '0;
		if (it.cmd == CMD_ADD) begin
			if (m_occ[it.slot]) begin
				r.add_error = 1'b1;
			end else begin
				b = (it.burst_length == '0) ? BURST_W'(1) : it.burst_length;
				m_occ[it.slot] = 1'b1;
				m_rem[it.slot] = b;
				m_orig[it.slot] = b;
				m_arr[it.slot] = m_now;
			end
		end else begin
			sel = choose_job();
			q = (m_quantum == 0) ? 8'd1 : m_quantum;
			if (sel >= 0) begin
				m_slice = (m_hact && m_hslot == sel && m_slice > 0) ? m_slice - 1'b1
					: q - 1'b1;
				if (m_rem[sel] > 0)
					m_rem[sel] = m_rem[sel] - 1'b1;
				r.ran_valid = 1'b1;
				r.ran_slot = SLOT_W'(sel);
				m_hslot = SLOT_W'(sel);
				if (m_rem[sel] == 0) begin
					m_occ[sel] = 1'b0;
					m_hact = 1'b0;
					r.job_done = 1'b1;
				end else begin
					m_hact = 1'b1;
				end
			end
			m_now = m_now + 1'b1;
		end
		return r;
	endfunction

	// issue one item; fixed expectation used where has_fixed is set
	task automatic issue(in_item_t it, logic has_fixed, out_item_t fixed);
		out_item_t p;
		start <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p = sched_step(it);
		sched_results.push_back(has_fixed ? fixed : p);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		start <= 1'b0;
		while (sched_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_POLICY)
			m_policy = val[2:0];
		else
			m_quantum = val;
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && done) begin
			if (sched_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", out_item);
			end else begin
				e = sched_results.pop_front();
				if (out_item.ran_valid !== e.ran_valid || out_item.ran_slot !== e.ran_slot ||
						out_item.job_done !== e.job_done || out_item.add_error !== e.add_error) begin
					errors++;
					if (errors <= 10)
						$display("result mismatch: expected %p actual %p", e, out_item);
				end
			end
		end
	end

	typedef struct {
		in_item_t it;
		logic has_fixed;
		out_item_t res;
	} row_t;

	row_t dir_rows [] = '{
		'{'{CMD_TICK, 4'd0, 12'd0}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0}},
		'{'{CMD_ADD, 4'd0, 12'd0}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0}},
		'{'{CMD_ADD, 4'd0, 12'd5}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b1}},
		'{'{CMD_TICK, 4'd15, 12'hfff}, 1'b1, '{1'b1, 4'd0, 1'b1, 1'b0}},
		'{'{CMD_ADD, 4'd15, 12'hfff}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0}},
		'{'{CMD_ADD, 4'd15, 12'd1}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b1}},
		'{'{CMD_ADD, 4'd5, 12'd2}, 1'b0, '0},
		'{'{CMD_ADD, 4'd10, 12'd1}, 1'b0, '0},
		'{'{CMD_TICK, 4'd0, 12'd0}, 1'b0, '0},
		'{'{CMD_TICK, 4'd0, 12'd0}, 1'b0, '0},
		'{'{CMD_ADD, 4'd3, 12'd3}, 1'b0, '0},
		'{'{CMD_TICK, 4'd0, 12'd0}, 1'b0, '0},
		'{'{CMD_TICK, 4'd0, 12'd0}, 1'b0, '0},
		'{'{CMD_ADD, 4'd15, 12'd7}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b1}}
	};

	// policy, quantum per phase
	logic [2:0] ph_pol [] = '{POL_RR, POL_RR, POL_SPN, POL_SRT, POL_HRRN, 3'd5, 3'd7, POL_RR,
		POL_FCFS, POL_SRT};
	logic [7:0] ph_q [] = '{8'd1, 8'd255, 8'd3, 8'd2, 8'd4, 8'd1, 8'd6, 8'd0, 8'd2, 8'd3};

	initial begin
		in_item_t it;
		for (int s = 0; s < NSLOT; s++)
			m_occ[s] = 1'b0;
		m_policy = POL_FCFS;
		m_quantum = 8'd2;
		m_now = '0;
		m_hslot = '0;
		m_hact = 1'b0;
		m_slice = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			issue(dir_rows[i].it, dir_rows[i].has_fixed, dir_rows[i].res);
		foreach (ph_pol[p]) begin
			write_reg(REG_POLICY, {5'($urandom), ph_pol[p]} & 8'h07 | {5'd0, ph_pol[p]});
			write_reg(REG_QUANTUM, ph_q[p]);
			case (p % 4)
				0: idle_pct = 0;
				1: idle_pct = 61;
				2: idle_pct = 0;
				default: idle_pct = 7;
			endcase
			for (int n = 0; n < 70; n++) begin
				it.cmd = ($urandom_range(99) < 55) ? CMD_TICK : CMD_ADD;
				it.slot = SLOT_W'($urandom);
				if ($urandom_range(99) < 4)
					it.burst_length = BURST_W'($urandom);
				else
					it.burst_length = BURST_W'($urandom_range(0, 6));
				issue(it, 1'b0, '0);
			end
		end
		// wide-data write to exercise upper bits of the policy register path
		write_reg(REG_POLICY, 8'hff);
		for (int n = 0; n < 10; n++) begin
			it = $bits(in_item_t)'($urandom);
			issue(it, 1'b0, '0);
		end
		start <= 1'b0;
		while (sched_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("cpu_job_scheduler_core: match");
		else
			$display("cpu_job_scheduler_core: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("cpu_job_scheduler_core: mismatch");
		$finish;
	end
endmodule
